>>> src/lps_pkg.sv
package lps_pkg;

    localparam int MAX_STEPS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_START = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    localparam logic [7:0] KIND_FIXED = 8'd0;
    localparam logic [7:0] KIND_RAMP  = 8'd1;
    localparam logic [7:0] KIND_BLINK = 8'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_KIND  = 3'd1;
    localparam logic [2:0] ST_ZERO_RAMP = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENTER_WAIT,
        S_ENTER_EXEC,
        S_TICK_WAIT,
        S_TICK_EXEC,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  step_kind;
        logic [31:0] duration_ms;
        logic [15:0] low_phase_ms;
        logic [15:0] high_phase_ms;
        logic [7:0]  cool_a;
        logic [7:0]  warm_a;
        logic [7:0]  cool_b;
        logic [7:0]  warm_b;
    } t_in_word;

    typedef struct packed {
        logic [7:0] cool_level;
        logic [7:0] warm_level;
        logic       running;
        logic [4:0] step_now;
        logic [2:0] status;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] dur;
        logic [15:0] high_ph;
        logic [15:0] low_ph;
        logic [31:0] levels;
    } t_step;

endpackage

>>> src/lps_div.sv
module lps_div import lps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [7:0]  o_quot
);

    logic [39:0] r_rem, n_rem;
    logic [39:0] r_dsh, n_dsh;
    logic [7:0]  r_q, n_q;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_num;
            n_dsh  = {1'b0, i_den, 7'd0};
            n_q    = 8'd0;
            n_cnt  = 3'd7;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = r_q | (8'd1 << r_cnt);
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 3'd1;
            if (r_cnt == 3'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> src/light_program_sequencer.sv
// Two-channel light program sequencer, cool and warm white.
// Input channel i_in_valid / o_in_ready carries one command word: load step,
// clear store, start run or one-millisecond tick. Every command word yields
// exactly one result word on o_out_valid / i_out_ready with the levels, run
// flag, step index and status after that command.
// Load, clear, idle start and idle tick go straight to the result state.
// A run start or a step change adds a memory read and an apply per step entered
// and a final pointer check when the run ends. A tick within a fixed or blink
// step passes a wait and an exec state; within a ramp it adds a multiply and
// the 8-step restoring divider, run once per channel.
// One command is in work at a time; the next is accepted only once the result
// slot is empty or is being emptied in that cycle.
// Reset clears the step count, pointer, levels and run flag; the step memory
// holds anything until loaded and only loaded entries are read.
// If the receiver stalls, the result word holds and no further command is
// accepted until that word is taken.
module light_program_sequencer import lps_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    t_step r_mem [MAX_STEPS];
    t_step r_rd;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [31:0] r_el, n_el;
    logic [15:0] r_pe, n_pe;
    logic        r_high, n_high;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_start, n_start;
    logic        r_run, n_run;
    logic [2:0]  r_status, n_status;
    logic        r_ch, n_ch;
    logic [39:0] r_num, n_num;
    logic [7:0]  r_qc, n_qc;
    logic        r_ovalid, n_ovalid;
    t_out_word   r_out, n_out;

    logic        w_accept, w_we, w_div_start, w_div_done;
    logic [7:0]  w_quot;
    logic [31:0] w_el_inc;
    logic [15:0] w_pe_inc, w_plen, w_pother;
    logic [7:0]  w_s, w_t;
    logic [2:0]  w_load_status;
    t_step       w_wr;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_el_inc    = r_el + 32'd1;
    assign w_pe_inc    = r_pe + 16'd1;
    assign w_plen      = r_high ? r_rd.high_ph : r_rd.low_ph;
    assign w_pother    = r_high ? r_rd.low_ph : r_rd.high_ph;
    assign w_s         = r_ch ? r_start[15:8] : r_start[7:0];
    assign w_t         = r_ch ? r_rd.levels[15:8] : r_rd.levels[7:0];
    assign w_div_start = (r_state == S_DIV_GO);

    assign w_wr.kind    = i_in_data.step_kind[1:0];
    assign w_wr.dur     = i_in_data.duration_ms;
    assign w_wr.high_ph = i_in_data.high_phase_ms;
    assign w_wr.low_ph  = i_in_data.low_phase_ms;
    assign w_wr.levels  = {i_in_data.warm_b, i_in_data.cool_b,
                           i_in_data.warm_a, i_in_data.cool_a};

    always_comb begin
        if (r_run)
            w_load_status = ST_BUSY;
        else if (i_in_data.step_kind > KIND_BLINK)
            w_load_status = ST_BAD_KIND;
        else if (i_in_data.step_kind == KIND_RAMP && i_in_data.duration_ms == 32'd0)
            w_load_status = ST_ZERO_RAMP;
        else if (r_count >= CW'(MAX_STEPS))
            w_load_status = ST_FULL;
        else
            w_load_status = ST_OK;
    end

    assign w_we = w_accept && (t_action'(i_in_data.action) == ACT_LOAD)
                  && (w_load_status == ST_OK);

    lps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_rd.dur),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_action'(i_in_data.action))
                        ACT_START: n_state = (!r_run && r_count != '0) ? S_ENTER_WAIT : S_OUT;
                        ACT_TICK:  n_state = (r_run && r_ptr < r_count) ? S_TICK_WAIT : S_OUT;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_ENTER_WAIT: n_state = (r_ptr < r_count) ? S_ENTER_EXEC : S_OUT;
            S_ENTER_EXEC: n_state = (r_rd.dur != 32'd0) ? S_OUT : S_ENTER_WAIT;
            S_TICK_WAIT:  n_state = S_TICK_EXEC;
            S_TICK_EXEC: begin
                if (r_rd.kind == KIND_RAMP[1:0])
                    n_state = S_MUL;
                else
                    n_state = (w_el_inc >= r_rd.dur) ? S_ENTER_WAIT : S_OUT;
            end
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done)
                    n_state = r_ch ? S_END : S_MUL;
            end
            S_END:   n_state = (r_el >= r_rd.dur) ? S_ENTER_WAIT : S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_el     = r_el;
        n_pe     = r_pe;
        n_high   = r_high;
        n_cur    = r_cur;
        n_start  = r_start;
        n_run    = r_run;
        n_status = r_status;
        n_ch     = r_ch;
        n_num    = r_num;
        n_qc     = r_qc;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    case (t_action'(i_in_data.action))
                        ACT_LOAD: begin
                            n_status = w_load_status;
                            if (w_load_status == ST_OK)
                                n_count = r_count + CW'(1);
                        end
                        ACT_CLEAR: begin
                            if (r_run) begin
                                n_status = ST_BUSY;
                            end else begin
                                n_count = '0;
                                n_ptr   = '0;
                            end
                        end
                        ACT_START: begin
                            if (r_run) begin
                                n_status = ST_BUSY;
                            end else if (r_count != '0) begin
                                n_run = 1'b1;
                                n_ptr = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ENTER_WAIT: begin
                if (r_ptr >= r_count) begin
                    n_run = 1'b0;
                    n_ptr = r_count;
                end
            end
            S_ENTER_EXEC: begin
                n_el    = '0;
                n_pe    = '0;
                n_start = r_cur;
                if (r_rd.kind == KIND_FIXED[1:0]) begin
                    n_cur = r_rd.levels[15:0];
                end else if (r_rd.kind == KIND_BLINK[1:0] && r_rd.dur != 32'd0) begin
                    n_high = !(r_rd.high_ph == 16'd0 && r_rd.low_ph != 16'd0);
                    n_cur  = n_high ? r_rd.levels[31:16] : r_rd.levels[15:0];
                end else if (r_rd.kind == KIND_RAMP[1:0] && r_rd.dur == 32'd0) begin
                    n_cur = r_rd.levels[15:0];
                end
                if (r_rd.dur == 32'd0)
                    n_ptr = r_ptr + CW'(1);
            end
            S_TICK_EXEC: begin
                n_el = w_el_inc;
                n_ch = 1'b0;
                if (r_rd.kind == KIND_BLINK[1:0]) begin
                    if (w_el_inc >= r_rd.dur) begin
                        n_cur = r_start;
                    end else begin
                        n_pe = w_pe_inc;
                        if (w_pe_inc >= w_plen) begin
                            if (w_pother != 16'd0)
                                n_high = !r_high;
                            n_pe  = '0;
                            n_cur = n_high ? r_rd.levels[31:16] : r_rd.levels[15:0];
                        end
                    end
                end
                if (r_rd.kind != KIND_RAMP[1:0] && w_el_inc >= r_rd.dur)
                    n_ptr = r_ptr + CW'(1);
            end
            S_MUL: begin
                n_num = 40'(w_s * (r_rd.dur - r_el)) + 40'(w_t * r_el);
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    if (r_ch) begin
                        n_cur = {w_quot, r_qc};
                    end else begin
                        n_qc = w_quot;
                        n_ch = 1'b1;
                    end
                end
            end
            S_END: begin
                if (r_el >= r_rd.dur)
                    n_ptr = r_ptr + CW'(1);
            end
            S_OUT: begin
                n_ovalid         = 1'b1;
                n_out.cool_level = r_cur[7:0];
                n_out.warm_level = r_cur[15:8];
                n_out.running    = r_run;
                n_out.step_now   = r_run ? 5'(r_ptr) : 5'(r_count);
                n_out.status     = r_status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[r_count[IW-1:0]] <= w_wr;
        r_rd <= r_mem[r_ptr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_el     <= '0;
            r_pe     <= '0;
            r_high   <= 1'b0;
            r_cur    <= '0;
            r_start  <= '0;
            r_run    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_el     <= n_el;
            r_pe     <= n_pe;
            r_high   <= n_high;
            r_cur    <= n_cur;
            r_start  <= n_start;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
        end
        r_status <= n_status;
        r_ch     <= n_ch;
        r_num    <= n_num;
        r_qc     <= n_qc;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_idle_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run) |-> (r_ptr < r_count))
        else $error("run active with pointer past the step count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_STEPS))
        else $error("step count beyond store depth");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!r_ovalid || i_out_ready))
        else $error("result overwrites a word still waiting");

endmodule

>>> tb/tb_light_program_sequencer.sv
`timescale 1ns / 100ps

module tb_light_program_sequencer import lps_pkg::*;;

    localparam int N_DIR = 23;
    localparam int N_RAND = 1500;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;

    light_program_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // sequencer shadow state
    logic [7:0]  sh_kind [MAX_STEPS_DEF];
    logic [31:0] sh_dur [MAX_STEPS_DEF];
    logic [15:0] sh_hi_ph [MAX_STEPS_DEF];
    logic [15:0] sh_lo_ph [MAX_STEPS_DEF];
    logic [31:0] sh_lv [MAX_STEPS_DEF];
    int unsigned sh_count, sh_ptr;
    logic [31:0] sh_elapsed;
    logic [15:0] sh_ph_elapsed;
    logic        sh_hi_phase;
    logic [15:0] sh_levels, sh_start_levels;
    logic        sh_running;

    t_out_word   level_q [$];
    int          errors;
    int          send_idle_pct, recv_stall_pct;

    function automatic logic [15:0] phase_of(int unsigned i, logic hi);
        return hi ? sh_hi_ph[i] : sh_lo_ph[i];
    endfunction

    function automatic void show_phase(int unsigned i);
        sh_levels = sh_hi_phase ? sh_lv[i][31:16] : sh_lv[i][15:0];
    endfunction

    function automatic logic [7:0] ramp_lv(logic [7:0] s, logic [7:0] t, logic [31:0] d,
                                           logic [31:0] e);
        logic [63:0] num;
        num = 64'(s) * 64'(d - e) + 64'(t) * 64'(e);
        return 8'(num / 64'(d));
    endfunction

    function automatic void enter_steps();
        int unsigned i;
        while (sh_ptr < sh_count) begin
            i = sh_ptr;
            sh_elapsed = '0;
            sh_ph_elapsed = '0;
            sh_start_levels = sh_levels;
            if (sh_kind[i] == KIND_FIXED) begin
                sh_levels = sh_lv[i][15:0];
            end else if (sh_kind[i] == KIND_BLINK && sh_dur[i] != 0) begin
                sh_hi_phase = !(phase_of(i, 1'b1) == 0 && phase_of(i, 1'b0) != 0);
                show_phase(i);
            end else if (sh_kind[i] == KIND_RAMP && sh_dur[i] == 0) begin
                sh_levels = sh_lv[i][15:0];
            end
            if (sh_dur[i] != 0) return;
            sh_ptr++;
        end
        sh_running = 1'b0;
        sh_ptr = sh_count;
    endfunction

    function automatic void advance_ms();
        int unsigned i;
        logic [31:0] d, e;
        i = sh_ptr;
        d = sh_dur[i];
        sh_elapsed++;
        if (sh_kind[i] == KIND_RAMP) begin
            e = (sh_elapsed > d) ? d : sh_elapsed;
            sh_levels = {ramp_lv(sh_start_levels[15:8], sh_lv[i][15:8], d, e),
                         ramp_lv(sh_start_levels[7:0], sh_lv[i][7:0], d, e)};
        end else if (sh_kind[i] == KIND_BLINK) begin
            if (sh_elapsed >= d) begin
                sh_levels = sh_start_levels;
            end else begin
                sh_ph_elapsed++;
                if (sh_ph_elapsed >= phase_of(i, sh_hi_phase)) begin
                    if (phase_of(i, !sh_hi_phase) != 0) sh_hi_phase = !sh_hi_phase;
                    sh_ph_elapsed = '0;
                    show_phase(i);
                end
            end
        end
        if (sh_elapsed >= d) begin
            sh_ptr++;
            enter_steps();
        end
    endfunction

    function automatic t_out_word predict_levels(t_in_word w);
        t_out_word r;
        logic [2:0] st;
        st = ST_OK;
        case (t_action'(w.action))
            ACT_LOAD: begin
                if (sh_running) st = ST_BUSY;
                else if (w.step_kind > KIND_BLINK) st = ST_BAD_KIND;
                else if (w.step_kind == KIND_RAMP && w.duration_ms == 0) st = ST_ZERO_RAMP;
                else if (sh_count >= MAX_STEPS_DEF) st = ST_FULL;
                else begin
                    sh_kind[sh_count] = w.step_kind;
                    sh_dur[sh_count] = w.duration_ms;
                    sh_hi_ph[sh_count] = w.high_phase_ms;
                    sh_lo_ph[sh_count] = w.low_phase_ms;
                    sh_lv[sh_count] = {w.warm_b, w.cool_b, w.warm_a, w.cool_a};
                    sh_count++;
                end
            end
            ACT_CLEAR: begin
                if (sh_running) st = ST_BUSY;
                else begin
                    sh_count = 0;
                    sh_ptr = 0;
                end
            end
            ACT_START: begin
                if (sh_running) st = ST_BUSY;
                else if (sh_count != 0) begin
                    sh_running = 1'b1;
                    sh_ptr = 0;
                    enter_steps();
                end
            end
            default: begin
                if (sh_running && sh_ptr < sh_count) advance_ms();
            end
        endcase
        r.cool_level = sh_levels[7:0];
        r.warm_level = sh_levels[15:8];
        r.running = sh_running;
        r.step_now = 5'(sh_running ? sh_ptr : sh_count);
        r.status = st;
        return r;
    endfunction

    function automatic t_in_word mk(t_action a, logic [7:0] k, logic [31:0] d,
                                    logic [15:0] lo, logic [15:0] hi, logic [31:0] lv);
        t_in_word w;
        w.action = a;
        w.step_kind = k;
        w.duration_ms = d;
        w.low_phase_ms = lo;
        w.high_phase_ms = hi;
        {w.warm_b, w.cool_b, w.warm_a, w.cool_a} = lv;
        return w;
    endfunction

    task automatic report(string fld, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", fld, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (level_q.size() == 0) begin
                report("unexpected word", 1, 0);
            end else begin
                t_out_word e;
                e = level_q.pop_front();
                if (o_out_data.cool_level !== e.cool_level)
                    report("cool_level", o_out_data.cool_level, e.cool_level);
                if (o_out_data.warm_level !== e.warm_level)
                    report("warm_level", o_out_data.warm_level, e.warm_level);
                if (o_out_data.running !== e.running)
                    report("running", o_out_data.running, e.running);
                if (o_out_data.step_now !== e.step_now)
                    report("step_now", o_out_data.step_now, e.step_now);
                if (o_out_data.status !== e.status)
                    report("status", o_out_data.status, e.status);
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send(t_in_word w, bit has_typed, t_out_word typed);
        t_out_word p;
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = predict_levels(w);
        level_q.insert(level_q.size(), has_typed ? typed : p);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_p(t_in_word w);
        send(w, 1'b0, '0);
    endtask

    function automatic logic [7:0] rnd_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return KIND_FIXED;
        if (r < 60) return KIND_RAMP;
        if (r < 92) return KIND_BLINK;
        return 8'($urandom_range(3, 255));
    endfunction

    function automatic t_in_word rnd_step();
        logic [31:0] d;
        logic [15:0] lo, hi;
        d = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
        lo = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        hi = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        return mk(ACT_LOAD, rnd_kind(), d, lo, hi, $urandom);
    endfunction

    t_in_word  dir_word [N_DIR];
    bit        dir_has [N_DIR];
    t_out_word dir_exp [N_DIR];

    initial begin
        int sent;
        int n;
        bit drained;
        t_in_word w;
        errors = 0;
        drained = 1'b0;
        sh_count = 0;
        sh_ptr = 0;
        sh_elapsed = '0;
        sh_ph_elapsed = '0;
        sh_hi_phase = 1'b0;
        sh_levels = '0;
        sh_start_levels = '0;
        sh_running = 1'b0;
        send_idle_pct = 18;
        recv_stall_pct = 52;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;

        dir_has = '{default: 1'b0};
        dir_exp = '{default: '0};
        dir_word[0] = mk(ACT_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        dir_has[0] = 1'b1;
        dir_word[1] = mk(ACT_START, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        dir_has[1] = 1'b1;
        dir_word[2] = mk(ACT_CLEAR, 8'hFF, '1, '1, '1, '1);
        dir_has[2] = 1'b1;
        dir_word[3] = mk(ACT_LOAD, 8'hFF, '1, '1, '1, '1);
        dir_has[3] = 1'b1;
        dir_exp[3].status = ST_BAD_KIND;
        dir_word[4] = mk(ACT_LOAD, KIND_RAMP, 32'd0, 16'd1, 16'd1, 32'h0);
        dir_has[4] = 1'b1;
        dir_exp[4].status = ST_ZERO_RAMP;
        dir_word[5] = mk(ACT_LOAD, KIND_FIXED, 32'd0, 16'd0, 16'd0, 32'h0000FFFF);
        dir_word[6] = mk(ACT_LOAD, KIND_RAMP, 32'd3, 16'd0, 16'd0, 32'h0000C80A);
        dir_word[7] = mk(ACT_LOAD, KIND_BLINK, 32'd6, 16'd1, 16'd2, 32'hFFFF0000);
        dir_word[8] = mk(ACT_LOAD, KIND_BLINK, 32'd0, 16'd1, 16'd1, 32'h12345678);
        dir_word[9] = mk(ACT_LOAD, KIND_BLINK, 32'd3, 16'd0, 16'd0, 32'h80807F7F);
        dir_word[10] = mk(ACT_LOAD, KIND_BLINK, 32'd4, 16'd2, 16'd0, 32'h55AA33CC);
        dir_word[11] = mk(ACT_START, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        dir_word[12] = mk(ACT_LOAD, KIND_FIXED, 32'd1, 16'd0, 16'd0, 32'd0);
        dir_word[13] = mk(ACT_CLEAR, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        dir_word[14] = mk(ACT_START, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        for (int i = 15; i < N_DIR; i++)
            dir_word[i] = mk(ACT_TICK, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send(dir_word[i], dir_has[i], dir_exp[i]);

        sent = 0;
        while (sent < N_RAND) begin
            if (sent >= 1000) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (sent >= 500) begin
                send_idle_pct = 52;
                recv_stall_pct = 18;
            end
            if (sent >= 750 && !drained) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                while (level_q.size() != 0) @(posedge i_clk);
            end
            if (sh_running) begin
                if ($urandom_range(19) == 0) begin
                    w = mk(t_action'($urandom_range(0, 2)), $urandom, $urandom,
                           $urandom, $urandom, $urandom);
                end else begin
                    w = mk(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                send_p(w);
                sent++;
            end else if ($urandom_range(99) < 75) begin
                send_p(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
                n = ($urandom_range(7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
                for (int k = 0; k < n; k++) send_p(rnd_step());
                send_p(mk(ACT_START, $urandom, $urandom, $urandom, $urandom, $urandom));
                sent += n + 2;
            end else begin
                // noise: never start, so oversized steps are cleared before any run
                w = mk(($urandom_range(2) == 0) ? ACT_TICK : ACT_LOAD, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
                if ($urandom_range(3) == 0) w.action = ACT_CLEAR;
                send_p(w);
                sent++;
            end
        end
        i_in_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS light_program_sequencer");
        end else begin
            $display("FAIL light_program_sequencer");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL light_program_sequencer");
        $finish;
    end

endmodule
